FILE: design/lcm3_pkg.sv
// ----------------------------------------------------------------------------
// lcm3_pkg: shared types and constants for the three-operand LCM engine
// State encoding, adder operation codes and the control/status bundles that
// run between the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lcm3_pkg;

  // width of the result word, fixed by the interface
  localparam int MULTIPLE_WIDTH = 48;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_GCD_TWO,
    ST_GCD_RUN,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } lcm3_state_t;

  // shared adder operation
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } lcm3_alu_op_t;

  // sequencer -> datapath
  typedef struct packed {
    logic         idle;        // ready for a new input word
    logic         gcd_init;    // load gcd operands for the current pass
    logic         sel_third;   // second pass: use running lcm and third operand
    logic         gcd_halve;   // strip a common factor of two
    logic         gcd_step;    // one binary gcd step
    logic         div_init;    // load divisor and numerator
    logic         div_step;    // one restoring division step
    logic         mul_init;    // clear product, load multiplicand
    logic         mul_step;    // one shift-add multiply step
    logic         out_load;    // move result into the output register
    lcm3_alu_op_t alu_op;
  } lcm3_ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic in_fire;    // input word accepted this cycle
    logic any_zero;   // accepted word has a zero operand
    logic u_odd;
    logic v_odd;
    logic diff_zero;  // gcd operands are equal
    logic out_free;   // output register can take a word
  } lcm3_stat_t;

endpackage

`default_nettype wire

FILE: design/lcm3_alu.sv
// ----------------------------------------------------------------------------
// lcm3_alu: shared add/subtract unit
// One carry chain used for gcd subtraction, division trial subtraction and
// the shift-add multiply accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module lcm3_alu #(
  parameter int WIDTH = 48
) (
  input  wire logic [WIDTH-1:0]     op_a,
  input  wire logic [WIDTH-1:0]     op_b,
  input  wire lcm3_pkg::lcm3_alu_op_t op,
  output logic      [WIDTH-1:0]     res,
  output logic                      borrow
);

  logic             is_sub;
  logic [WIDTH-1:0] b_in;
  logic [WIDTH:0]   sum;

  // subtract as a + ~b + 1
  always_comb begin
    is_sub = (op == lcm3_pkg::ALU_SUB);
    b_in   = is_sub ? ~op_b : op_b;
    sum    = {1'b0, op_a} + {1'b0, b_in} + {{WIDTH{1'b0}}, is_sub};
    res    = sum[WIDTH-1:0];
    borrow = is_sub & ~sum[WIDTH];
  end

endmodule

`default_nettype wire

FILE: design/lcm3_seq.sv
// ----------------------------------------------------------------------------
// lcm3_seq: sequencer for the LCM engine
// Steps two passes of gcd -> divide -> multiply over the shared adder (none if
// an operand is zero) and counts the bit-serial division and multiply steps.
// ----------------------------------------------------------------------------
`default_nettype none

module lcm3_seq #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lcm3_pkg::lcm3_stat_t stat,
  output lcm3_pkg::lcm3_ctrl_t    ctrl
);

  localparam int CNT_W = $clog2(OPERAND_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_WIDTH - 1);

  lcm3_pkg::lcm3_state_t state_r, state_nxt;
  logic                  pass_r, pass_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  // state, pass and step counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcm3_pkg::ST_IDLE;
      pass_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state and control
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    cnt_nxt   = cnt_r;
    ctrl      = '0;
    ctrl.alu_op    = lcm3_pkg::ALU_SUB;
    ctrl.sel_third = pass_r;

    unique case (state_r)
      lcm3_pkg::ST_IDLE: begin
        ctrl.idle = 1'b1;
        if (stat.in_fire) begin
          pass_nxt  = 1'b0;
          state_nxt = stat.any_zero ? lcm3_pkg::ST_DONE : lcm3_pkg::ST_INIT;
        end
      end
      lcm3_pkg::ST_INIT: begin
        ctrl.gcd_init = 1'b1;
        state_nxt     = lcm3_pkg::ST_GCD_TWO;
      end
      lcm3_pkg::ST_GCD_TWO: begin
        if (!stat.u_odd && !stat.v_odd) begin
          ctrl.gcd_halve = 1'b1;
        end else begin
          state_nxt = lcm3_pkg::ST_GCD_RUN;
        end
      end
      lcm3_pkg::ST_GCD_RUN: begin
        // operands meet only when both are odd: that value is the odd gcd part
        if (stat.diff_zero) begin
          ctrl.div_init = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = lcm3_pkg::ST_DIV;
        end else begin
          ctrl.gcd_step = 1'b1;
        end
      end
      lcm3_pkg::ST_DIV: begin
        ctrl.div_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          ctrl.mul_init = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = lcm3_pkg::ST_MUL;
        end
      end
      lcm3_pkg::ST_MUL: begin
        ctrl.mul_step = 1'b1;
        ctrl.alu_op   = lcm3_pkg::ALU_ADD;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt = '0;
          if (pass_r) begin
            state_nxt = lcm3_pkg::ST_DONE;
          end else begin
            pass_nxt  = 1'b1;
            state_nxt = lcm3_pkg::ST_INIT;
          end
        end
      end
      lcm3_pkg::ST_DONE: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          state_nxt     = lcm3_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lcm3_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/lcm_of_three_core.sv
// ----------------------------------------------------------------------------
// lcm_of_three_core: least common multiple of three unsigned operands
// Pairwise reduction lcm(a,b) = a * (b / gcd(a,b)), then with the third
// operand, all on one shared adder under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word of three operands.
//   Result channel (out_valid/out_ready) returns one word per input: the
//   LCM, or zero with out_zero_operand set when any operand is zero.
//   in_ready is high only while the engine is idle; one word is in flight.
// Sequence:
//   Each of two passes runs a binary gcd (one shift, swap or subtract per
//   cycle), then W restoring division steps and W shift-add multiply steps,
//   W = OPERAND_WIDTH; the gcd loops make the run time data dependent.
//   A zero operand skips the arithmetic.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// Stall: a finished result waits in the accumulator; the engine holds
//   its done state until the output register frees and only then takes new input.
// ----------------------------------------------------------------------------
`default_nettype none

module lcm_of_three_core #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [OPERAND_WIDTH-1:0] in_first_value,
  input  wire logic [OPERAND_WIDTH-1:0] in_second_value,
  input  wire logic [OPERAND_WIDTH-1:0] in_third_value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [lcm3_pkg::MULTIPLE_WIDTH-1:0] out_multiple,
  output logic                          out_zero_operand
);

  localparam int W     = OPERAND_WIDTH;
  localparam int D     = 2 * W;                 // gcd and partial lcm width
  localparam int P     = 3 * W;                 // full lcm width
  localparam int K_W   = $clog2(W + 1);         // common power-of-two count
  localparam int MW    = lcm3_pkg::MULTIPLE_WIDTH;

  lcm3_pkg::lcm3_ctrl_t ctrl;
  lcm3_pkg::lcm3_stat_t stat;

  logic [D-1:0]   m_r;      // first operand, later the running lcm
  logic [W-1:0]   b_r;
  logic [W-1:0]   c_r;
  logic [D-1:0]   u_r;
  logic [D-1:0]   v_r;
  logic [K_W-1:0] k_r;
  logic [W-1:0]   dvs_r;    // divisor: gcd of the pass
  logic [W-1:0]   rem_r;
  logic [W-1:0]   quo_r;    // numerator in, quotient out, then multiplier
  logic [P-1:0]   acc_r;
  logic [P-1:0]   mcd_r;
  logic           err_r;
  logic           out_valid_r;
  logic [MW-1:0]  out_multiple_r;
  logic           out_zero_r;

  logic           in_fire;
  logic           any_zero;
  logic [W:0]     rem_sh;
  logic [D-1:0]   g_full;
  logic [P-1:0]   alu_a;
  logic [P-1:0]   alu_b;
  logic [P-1:0]   alu_res;
  logic           alu_borrow;
  logic           qbit;
  logic [P+MW-1:0] acc_ext;

  // handshake and status
  assign in_ready = ctrl.idle;
  assign in_fire  = in_valid & ctrl.idle;
  assign any_zero = (in_first_value == '0) | (in_second_value == '0) |
                    (in_third_value == '0);

  always_comb begin
    stat.in_fire   = in_fire;
    stat.any_zero  = any_zero;
    stat.u_odd     = u_r[0];
    stat.v_odd     = v_r[0];
    stat.diff_zero = (alu_res == '0);
    stat.out_free  = ~out_valid_r | out_ready;
  end

  lcm3_seq #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctrl (ctrl)
  );

  // adder operand select
  assign rem_sh = {rem_r, quo_r[W-1]};
  assign g_full = u_r << k_r;

  always_comb begin
    if (ctrl.div_step) begin
      alu_a = P'(rem_sh);
      alu_b = P'(dvs_r);
    end else if (ctrl.mul_step) begin
      alu_a = acc_r;
      alu_b = mcd_r;
    end else begin
      alu_a = P'(u_r);
      alu_b = P'(v_r);
    end
  end

  lcm3_alu #(
    .WIDTH(P)
  ) u_alu (
    .op_a  (alu_a),
    .op_b  (alu_b),
    .op    (ctrl.alu_op),
    .res   (alu_res),
    .borrow(alu_borrow)
  );

  assign qbit = ~alu_borrow;

  // operand capture and gcd registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_r   <= D'(in_first_value);
      b_r   <= in_second_value;
      c_r   <= in_third_value;
      err_r <= any_zero;
    end else if (ctrl.gcd_init && ctrl.sel_third) begin
      m_r <= acc_r[D-1:0];
    end

    if (ctrl.gcd_init) begin
      u_r <= ctrl.sel_third ? acc_r[D-1:0] : m_r;
      v_r <= ctrl.sel_third ? D'(c_r) : D'(b_r);
      k_r <= '0;
    end else if (ctrl.gcd_halve) begin
      u_r <= u_r >> 1;
      v_r <= v_r >> 1;
      k_r <= k_r + 1'b1;
    end else if (ctrl.gcd_step) begin
      if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (alu_borrow) begin
        // keep u the larger one
        u_r <= v_r;
        v_r <= u_r;
      end else begin
        u_r <= alu_res[D-1:0];
      end
    end
  end

  // division and multiply registers
  always_ff @(posedge clk) begin
    if (ctrl.div_init) begin
      dvs_r <= g_full[W-1:0];
      rem_r <= '0;
      quo_r <= ctrl.sel_third ? c_r : b_r;
    end else if (ctrl.div_step) begin
      rem_r <= qbit ? alu_res[W-1:0] : rem_sh[W-1:0];
      quo_r <= {quo_r[W-2:0], qbit};
    end else if (ctrl.mul_step) begin
      quo_r <= quo_r >> 1;
    end

    if (in_fire) begin
      acc_r <= '0;
    end else if (ctrl.mul_init) begin
      acc_r <= '0;
      mcd_r <= P'(m_r);
    end else if (ctrl.mul_step) begin
      if (quo_r[0]) begin
        acc_r <= alu_res;
      end
      mcd_r <= mcd_r << 1;
    end
  end

  // output register
  assign acc_ext = {{MW{1'b0}}, acc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_multiple_r <= err_r ? '0 : acc_ext[MW-1:0];
      out_zero_r     <= err_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_multiple     = out_multiple_r;
  assign out_zero_operand = out_zero_r;

endmodule

`default_nettype wire
